// ----- src/gf2_xor_basis_engine_assert.svh -----
// ----------------------------------------------------------------------------
// gf2_xor_basis_engine assertion macros
// Concurrent assertion shorthands, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef GF2_XOR_BASIS_ENGINE_ASSERT_SVH
`define GF2_XOR_BASIS_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define GXB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gf2_xor_basis_engine assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GXB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gf2_xor_basis_engine assertion failed");

`else

`define GXB_ASSERT_SAME(label, ante, cons)
`define GXB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/gxb_pkg.sv -----
// ----------------------------------------------------------------------------
// gxb_pkg
// Shared types and opcodes of the GF(2) XOR basis engine.
// ----------------------------------------------------------------------------
package gxb_pkg;

    // Fixed port widths.
    localparam int VecW  = 64;
    localparam int RankW = 7;

    // Opcodes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TEST   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [1:0]      opcode;
        logic [VecW-1:0] vector_bits;
    } t_gxb_in;

    // Result beat.
    typedef struct packed {
        logic             independent;
        logic [RankW-1:0] rank;
    } t_gxb_out;

    // Beat moving along the cell chain.
    typedef struct packed {
        logic            valid;
        logic [1:0]      op;
        logic [VecW-1:0] vec;
        logic            found;
    } t_gxb_stage;

endpackage

// ----- src/gxb_cell.sv -----
// ----------------------------------------------------------------------------
// gxb_cell
// One basis slot: holds the row whose lowest set bit is POS and reduces the
// passing vector against it, storing the vector on an insert into an empty slot.
// ----------------------------------------------------------------------------
module gxb_cell #(
    parameter int POS = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  gxb_pkg::t_gxb_stage i_beat,
    output gxb_pkg::t_gxb_stage o_beat
);
    import gxb_pkg::*;

    t_gxb_stage      r_beat, n_beat;
    logic [VecW-1:0] r_row, n_row;
    logic            r_filled, n_filled;

    // Reduce the incoming beat against this slot.
    always_comb begin
        n_beat   = i_beat;
        n_row    = r_row;
        n_filled = r_filled;
        if (i_beat.valid) begin
            case (i_beat.op)
                OP_INSERT, OP_TEST: begin
                    if (!i_beat.found && i_beat.vec[POS]) begin
                        if (r_filled) begin
                            n_beat.vec = i_beat.vec ^ r_row;
                        end else begin
                            // First empty slot met: the vector is independent.
                            n_beat.found = 1'b1;
                            if (i_beat.op == OP_INSERT) begin
                                n_row    = i_beat.vec;
                                n_filled = 1'b1;
                            end
                        end
                    end
                end
                OP_CLEAR: begin
                    n_filled = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Slot state and the beat handed to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
            r_filled     <= 1'b0;
        end else if (i_adv) begin
            r_beat   <= n_beat;
            r_filled <= n_filled;
        end
    end

    // Row payload needs no reset; the filled bit qualifies it.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_row <= n_row;
        end
    end

    assign o_beat = r_beat;

endmodule

// ----- src/gxb_out.sv -----
// ----------------------------------------------------------------------------
// gxb_out
// Output register and rank counter at the end of the cell chain; also makes
// the chain advance signal from the output handshake.
// ----------------------------------------------------------------------------
module gxb_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gxb_pkg::t_gxb_stage i_beat,
    input  logic                i_ready,
    output logic                o_adv,
    output logic                o_valid,
    output gxb_pkg::t_gxb_out   o_result
);
    import gxb_pkg::*;

    logic             r_valid, n_valid;
    logic [RankW-1:0] r_rank, n_rank;
    t_gxb_out         r_result, n_result;

    // The chain moves whenever the output register is free or being drained.
    assign o_adv = !r_valid || i_ready;

    // Rank update in item order as beats leave the chain.
    always_comb begin
        n_rank = r_rank;
        if (o_adv && i_beat.valid) begin
            case (i_beat.op)
                OP_INSERT: begin
                    if (i_beat.found) begin
                        n_rank = r_rank + RankW'(1);
                    end
                end
                OP_CLEAR: begin
                    n_rank = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Next result beat.
    always_comb begin
        n_result.independent = i_beat.found;
        n_result.rank        = n_rank;
        n_valid              = o_adv ? i_beat.valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- src/gf2_xor_basis_engine.sv -----
// Path: an accepted beat passes the register of each basis cell, then the
// output register. Throughput: one beat per cycle unless the output stalls;
// each cell updates its slot as a beat passes, so later beats always see the
// basis left by earlier ones.
// Reset (i_rst_n low, synchronous): all slots empty, rank zero, chain empty.
// ----------------------------------------------------------------------------
// gf2_xor_basis_engine
// Incremental GF(2) linear basis built as a chain of slot cells, one per bit.
// ----------------------------------------------------------------------------
`include "gf2_xor_basis_engine_assert.svh"

module gf2_xor_basis_engine #(
    parameter int VECTOR_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gxb_pkg::t_gxb_in  i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gxb_pkg::t_gxb_out o_out_beat
);
    import gxb_pkg::*;

    // Coordinates at and above VECTOR_BITS are ignored.
    localparam logic [VecW-1:0] VecMask =
        (VECTOR_BITS >= VecW) ? {VecW{1'b1}} : ((VecW'(1) << VECTOR_BITS) - VecW'(1));

    t_gxb_stage w_stage [0:VECTOR_BITS];
    logic       w_adv;
    logic       w_clear_out;

    // Entry beat.
    always_comb begin
        w_stage[0].valid = i_in_valid;
        w_stage[0].op    = i_in_beat.opcode;
        w_stage[0].vec   = i_in_beat.vector_bits & VecMask;
        w_stage[0].found = 1'b0;
    end

    // One cell per basis slot.
    for (genvar g = 0; g < VECTOR_BITS; g++) begin : g_cell
        gxb_cell #(
            .POS (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_beat  (w_stage[g]),
            .o_beat  (w_stage[g+1])
        );
    end

    // Result register and rank counter.
    gxb_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (w_stage[VECTOR_BITS]),
        .i_ready  (i_out_ready),
        .o_adv    (w_adv),
        .o_valid  (o_out_valid),
        .o_result (o_out_beat)
    );

    assign o_in_ready = w_adv;

    // A clear beat moving into the output register.
    assign w_clear_out = w_adv && w_stage[VECTOR_BITS].valid &&
                         (w_stage[VECTOR_BITS].op == OP_CLEAR);

    // A clear leaving the chain yields a dependent result of rank zero.
    `GXB_ASSERT_NEXT(a_clear_result, w_clear_out, !o_out_beat.independent && (o_out_beat.rank == '0))
    // The rank never exceeds the number of slots.
    `GXB_ASSERT_SAME(a_rank_bound, o_out_valid, o_out_beat.rank <= RankW'(VECTOR_BITS))
    // A stalled output register holds back the input side.
    `GXB_ASSERT_SAME(a_stall_input, o_out_valid && !i_out_ready, !o_in_ready)

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the GF(2) XOR basis engine. A short directed run
// covers zero vectors, full and single-bit vectors, clears and the unused
// opcode. Random sequences follow: span building, full-rank fills and noise.
// A basis tracker predicts every result and checks each one in order.
// ----------------------------------------------------------------------------
module testbench;
    import gxb_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int          RESET_CYCLES = 9;
    localparam int          RANDOM_ITEMS = 600;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          HOLD_ITEMS   = 150;
    localparam int          PIPE_CYCLES  = VecW + 1;
    localparam int          RUN_LIMIT_NS = 5_000_000;
    localparam logic [1:0]  OP_NOP       = 2'd3;
    localparam logic [63:0] ALL_ONES     = {VecW{1'b1}};

    // Tracks the span of every accepted vector and holds the results owed.
    class basis_tracker;
        logic [VecW-1:0]  span_rows [VecW];
        logic [RankW-1:0] rank_now;
        t_gxb_out         expected_outcomes [$];
        int               failures;

        // The basis starts empty, as after reset.
        function new();
            foreach (span_rows[p]) span_rows[p] = '0;
            rank_now = '0;
            failures = 0;
        endfunction

        function void absorb_vector(t_gxb_in beat);
            logic [VecW-1:0] v;
            t_gxb_out        want;
            bit              placed;
            v      = beat.vector_bits;
            want   = '0;
            placed = 1'b0;
            case (beat.opcode)
                OP_INSERT, OP_TEST: begin
                    // Walk upward from bit 0, folding in each filled row met.
                    for (int p = 0; p < VecW; p++) begin
                        if (!placed && v[p]) begin
                            if (span_rows[p] == '0) begin
                                placed           = 1'b1;
                                want.independent = 1'b1;
                                if (beat.opcode == OP_INSERT) begin
                                    span_rows[p] = v;
                                    rank_now     = rank_now + RankW'(1);
                                end
                            end else begin
                                v ^= span_rows[p];
                            end
                        end
                    end
                end
                OP_CLEAR: begin
                    foreach (span_rows[p]) span_rows[p] = '0;
                    rank_now = '0;
                end
                default: begin
                    // The unused opcode leaves the basis alone.
                end
            endcase
            want.rank = rank_now;
            expected_outcomes = {expected_outcomes, want};
        endfunction

        function void check_outcome(t_gxb_out got);
            t_gxb_out want;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: result beat with nothing owed: independent=%0b rank=%0d",
                         $time, got.independent, got.rank);
                failures++;
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.independent !== want.independent) begin
                $display("%0t: independent mismatch: expected %0b, actual %0b",
                         $time, want.independent, got.independent);
                failures++;
            end
            if (got.rank !== want.rank) begin
                $display("%0t: rank mismatch: expected %0d, actual %0d",
                         $time, want.rank, got.rank);
                failures++;
            end
        endfunction

        function int owed();
            return expected_outcomes.size();
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_gxb_in   i_in_beat   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_gxb_out  o_out_beat;

    basis_tracker    tracker = new;
    logic [63:0]     inserted_vectors [$];
    int              sent_count = 0;
    bit              calm       = 1'b0;
    bit              rx_hold    = 1'b0;
    bit              rx_holding = 1'b0;

    gf2_xor_basis_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Mostly no gap, some short ones and a few long ones; none in calm stretches.
    function automatic int idle_length();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 12);
    endfunction

    // Vectors shaped to hit sparse, high-slot, in-span and full patterns.
    function automatic logic [63:0] shaped_vector();
        logic [63:0] v;
        v = '0;
        case ($urandom_range(6))
            0: v = {$urandom, $urandom};
            1: repeat ($urandom_range(3, 1)) v[$urandom_range(63)] = 1'b1;
            2: v = {$urandom, $urandom} << $urandom_range(63);
            3, 4: begin
                // A sum of earlier inserts lies in the span.
                if (inserted_vectors.size() > 0) begin
                    repeat ($urandom_range(4, 1))
                        v ^= inserted_vectors[$urandom_range(inserted_vectors.size() - 1)];
                end
            end
            5: v = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: v = $urandom_range(1) ? ALL_ONES : '0;
        endcase
        return v;
    endfunction

    // Offers one beat and returns at the edge where it is taken.
    task automatic send_beat(input logic [1:0] op, input logic [63:0] vec);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= '{opcode: op, vector_bits: vec};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_count++;
        if (op == OP_INSERT) inserted_vectors = {inserted_vectors, vec};
        else if (op == OP_CLEAR) inserted_vectors.delete();
    endtask

    // Drops valid so no beat is repeated while the sender waits on something else.
    task automatic pause_sender();
        i_in_valid <= 1'b0;
    endtask

    // Input and result beats are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) tracker.check_outcome(o_out_beat);
            if (i_in_valid && o_in_ready) tracker.absorb_vector(i_in_beat);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                rx_holding = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold    = 1'b0;
                rx_holding = 1'b0;
            end
            stall = idle_length();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    end

    // Stimulus and end of run.
    initial begin
        int          target;
        int          n;
        bit          up;
        bit          held;
        bit          drained;
        logic [1:0]  op;
        logic [63:0] v;

        held    = 1'b0;
        drained = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vectors, single and full bit patterns, clear, unused opcode.
        send_beat(OP_INSERT, '0);
        send_beat(OP_TEST,   '0);
        send_beat(OP_INSERT, 64'd1);
        send_beat(OP_INSERT, 64'd1);
        send_beat(OP_TEST,   64'd1);
        send_beat(OP_INSERT, ALL_ONES);
        send_beat(OP_INSERT, 64'h8000_0000_0000_0000);
        send_beat(OP_TEST,   64'h8000_0000_0000_0000);
        send_beat(OP_TEST,   64'h4000_0000_0000_0000);
        send_beat(OP_INSERT, 64'hC000_0000_0000_0000);
        send_beat(OP_NOP,    ALL_ONES);
        send_beat(OP_TEST,   ALL_ONES);
        send_beat(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(OP_INSERT, 64'h5555_5555_5555_5555);
        send_beat(OP_CLEAR,  ALL_ONES);
        send_beat(OP_TEST,   ALL_ONES);
        send_beat(OP_NOP,    '0);
        send_beat(OP_INSERT, 64'h8000_0000_0000_0001);
        send_beat(OP_TEST,   64'h8000_0000_0000_0001);
        send_beat(OP_INSERT, 64'h8000_0000_0000_0000);
        send_beat(OP_CLEAR,  '0);
        send_beat(OP_TEST,   '0);

        // Let the directed part finish before random traffic starts.
        pause_sender();
        do @(posedge i_clk); while (tracker.owed() != 0);

        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target) begin
            calm = ($urandom_range(5) == 0);

            // Once: a long receiver hold-off while the sender keeps pushing.
            if (!held && sent_count > target - (2 * RANDOM_ITEMS) / 3) begin
                held = 1'b1;
                pause_sender();
                rx_hold = 1'b1;
                do @(posedge i_clk); while (!rx_holding);
                calm = 1'b1;
                repeat (HOLD_ITEMS)
                    send_beat($urandom_range(3) == 0 ? OP_TEST : OP_INSERT, shaped_vector());
                calm = 1'b0;
            end

            // Once: the sender waits until every owed result is back.
            if (!drained && sent_count > target - RANDOM_ITEMS / 3) begin
                drained = 1'b1;
                pause_sender();
                do @(posedge i_clk); while (tracker.owed() != 0);
            end

            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    // Build a span with mixed inserts and tests.
                    if ($urandom_range(2) == 0) send_beat(OP_CLEAR, {$urandom, $urandom});
                    n = $urandom_range(40, 5);
                    repeat (n) begin
                        case ($urandom_range(19))
                            0:                       op = OP_NOP;
                            1, 2, 3, 4, 5, 6:        op = OP_TEST;
                            default:                 op = OP_INSERT;
                        endcase
                        send_beat(op, shaped_vector());
                    end
                end
                6, 7: begin
                    // Fill every slot, then probe the full basis.
                    send_beat(OP_CLEAR, {$urandom, $urandom});
                    up = $urandom_range(1);
                    for (int i = 0; i < VecW; i++) begin
                        v = ({$urandom, $urandom} | 64'd1) << (up ? i : VecW - 1 - i);
                        send_beat(OP_INSERT, v);
                    end
                    repeat ($urandom_range(8, 2))
                        send_beat($urandom_range(1) ? OP_TEST : OP_INSERT, shaped_vector());
                end
                default: begin
                    // Noise: any opcode with any vector.
                    repeat ($urandom_range(12, 3))
                        send_beat(2'($urandom_range(3)), {$urandom, $urandom});
                end
            endcase
        end
        calm = 1'b0;

        // Wait for every owed result, then watch for stray ones.
        pause_sender();
        do @(posedge i_clk); while (tracker.owed() != 0);
        repeat (2 * PIPE_CYCLES + 10) @(posedge i_clk);

        if (tracker.failures == 0 && tracker.owed() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Run limit in case the block stops answering.
    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
